// File: hdl/dnd_pkg.sv
// Shared constants, codes and types of the DNS name decompressor.
// Used by the walker, the output packer and the top level.
package dnd_pkg;

  localparam int PACKET_DEPTH = 1024;
  localparam int NAME_MAX     = 255;
  localparam int HOP_LIMIT    = 16;

  localparam int ADDR_W = $clog2(PACKET_DEPTH);
  // A position holds a 14-bit pointer target plus one, so up to 16384.
  localparam int POS_W  = 15;
  localparam int HOP_W  = $clog2(HOP_LIMIT + 1);
  localparam int CNT_W  = 8;
  localparam int CONS_W = 9;

  localparam logic [7:0] PTR_MARK = 8'd192;
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LONG  = 2'd1;
  localparam logic [1:0] ST_HOPS  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Walker to packer: one character and/or the end of a decode.
  typedef struct packed {
    logic              push;
    logic [7:0]        ch;
    logic              finish;
    logic [1:0]        status;
    logic [CONS_W-1:0] consumed;
  } dnd_event_t;

  // Packer to walker.
  typedef struct packed {
    logic hold;
    logic busy;
  } dnd_pk_stat_t;

endpackage

// File: hdl/dnd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module dnd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/dnd_walker.sv
// Request handling and the name walk over packet memory, one byte a cycle unless the packer holds the walk.
// Depends on dnd_pkg; drives the packet RAM and feeds dnd_packer.
module dnd_walker
  import dnd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_command,
  input  logic [9:0]        in_byte_address,
  input  logic [7:0]        in_byte_value,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [7:0]        ram_wdata,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [7:0]        ram_rdata,
  input  dnd_pk_stat_t      pk,
  output dnd_event_t        ev
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  localparam logic [1:0] PH_LEN  = 2'd0;
  localparam logic [1:0] PH_PTR2 = 2'd1;
  localparam logic [1:0] PH_CHAR = 2'd2;

  logic              state_r, state_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [5:0]        hi_r, hi_nxt;
  logic [7:0]        rem_r, rem_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [HOP_W-1:0]  hops_r, hops_nxt;
  logic [CONS_W-1:0] consumed_r, consumed_nxt;
  logic              jumped_r, jumped_nxt;
  logic              first_r, first_nxt;

  logic [POS_W-1:0]  start_pos;
  logic [POS_W-1:0]  rd_pos;
  logic [POS_W-1:0]  pos_inc;
  logic [CONS_W-1:0] cons_inc;
  logic              accept;
  logic              fin;
  logic [1:0]        st;
  logic [7:0]        b;

  assign start_pos = POS_W'(in_byte_address);
  assign pos_inc   = pos_r + POS_W'(1);
  assign cons_inc  = consumed_r + CONS_W'(!jumped_r);
  assign b         = ram_rdata;
  assign ram_waddr = start_pos[ADDR_W-1:0];
  assign ram_wdata = in_byte_value;
  assign ram_raddr = rd_pos[ADDR_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    hi_nxt       = hi_r;
    rem_nxt      = rem_r;
    n_nxt        = n_r;
    hops_nxt     = hops_r;
    consumed_nxt = consumed_r;
    jumped_nxt   = jumped_r;
    first_nxt    = first_r;
    rd_pos       = pos_r;
    ram_we       = 1'b0;
    in_stall     = 1'b1;
    accept       = 1'b0;
    fin          = 1'b0;
    st           = ST_OK;
    ev           = '0;

    unique case (state_r)
      S_IDLE: begin
        in_stall = pk.busy;
        accept   = in_valid && !pk.busy;
        rd_pos   = start_pos;
        if (accept) begin
          if (in_command == CMD_LOAD) begin
            ram_we = start_pos < POS_W'(PACKET_DEPTH);
          end else if (start_pos < POS_W'(PACKET_DEPTH)) begin
            state_nxt    = S_WALK;
            phase_nxt    = PH_LEN;
            pos_nxt      = start_pos;
            n_nxt        = '0;
            hops_nxt     = '0;
            consumed_nxt = '0;
            jumped_nxt   = 1'b0;
            first_nxt    = 1'b1;
          end else begin
            ev.finish = 1'b1;
            ev.status = ST_RANGE;
          end
        end
      end
      S_WALK: begin
        // Every byte that reaches here was fetched in range; it counts only until the first pointer jump.
        consumed_nxt = cons_inc;
        unique case (phase_r)
          PH_LEN: begin
            if (b == 8'd0) begin
              fin = 1'b1;
            end else if (b >= PTR_MARK) begin
              hi_nxt    = b[5:0];
              pos_nxt   = pos_inc;
              phase_nxt = PH_PTR2;
            end else if (!first_r && n_r >= CNT_W'(NAME_MAX)) begin
              fin = 1'b1;
              st  = ST_LONG;
            end else begin
              if (!first_r) begin
                ev.push = 1'b1;
                ev.ch   = DOT_CHAR;
                n_nxt   = n_r + CNT_W'(1);
              end
              first_nxt = 1'b0;
              rem_nxt   = b;
              pos_nxt   = pos_inc;
              phase_nxt = PH_CHAR;
            end
          end
          PH_PTR2: begin
            if (hops_r >= HOP_W'(HOP_LIMIT)) begin
              fin = 1'b1;
              st  = ST_HOPS;
            end else begin
              // Dropping the two marker bits is the same as subtracting 49152.
              hops_nxt   = hops_r + HOP_W'(1);
              jumped_nxt = 1'b1;
              pos_nxt    = POS_W'({hi_r, b});
              phase_nxt  = PH_LEN;
            end
          end
          default: begin
            if (n_r >= CNT_W'(NAME_MAX)) begin
              fin = 1'b1;
              st  = ST_LONG;
            end else begin
              ev.push   = 1'b1;
              ev.ch     = b;
              n_nxt     = n_r + CNT_W'(1);
              rem_nxt   = rem_r - 8'd1;
              pos_nxt   = pos_inc;
              phase_nxt = (rem_r == 8'd1) ? PH_LEN : PH_CHAR;
            end
          end
        endcase
        if (!fin && pos_nxt >= POS_W'(PACKET_DEPTH)) begin
          fin = 1'b1;
          st  = ST_RANGE;
        end
        ev.finish   = fin;
        ev.status   = st;
        ev.consumed = (st == ST_OK) ? cons_inc : '0;
        rd_pos      = pos_nxt;
        if (fin) begin
          state_nxt = S_IDLE;
        end
        // A full word that cannot leave freezes the walk; the same byte is
        // read again so that it is still there next cycle.
        if (pk.hold) begin
          state_nxt    = state_r;
          phase_nxt    = phase_r;
          pos_nxt      = pos_r;
          hi_nxt       = hi_r;
          rem_nxt      = rem_r;
          n_nxt        = n_r;
          hops_nxt     = hops_r;
          consumed_nxt = consumed_r;
          jumped_nxt   = jumped_r;
          first_nxt    = first_r;
          rd_pos       = pos_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    phase_r    <= phase_nxt;
    pos_r      <= pos_nxt;
    hi_r       <= hi_nxt;
    rem_r      <= rem_nxt;
    n_r        <= n_nxt;
    hops_r     <= hops_nxt;
    consumed_r <= consumed_nxt;
    jumped_r   <= jumped_nxt;
    first_r    <= first_nxt;
  end

endmodule

// File: hdl/dnd_packer.sv
// Packs decoded characters four to a word and holds the output register.
// Depends on dnd_pkg; takes events from dnd_walker.
module dnd_packer
  import dnd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dnd_event_t        ev,
  output dnd_pk_stat_t      pk,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_name_chars,
  output logic [2:0]        out_char_count,
  output logic [CONS_W-1:0] out_bytes_consumed,
  output logic [1:0]        out_decode_status,
  output logic              out_last_result
);

  logic [31:0]       word_r, word_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [1:0]        fst_r, fst_nxt;
  logic [CONS_W-1:0] fcons_r, fcons_nxt;

  logic              ov_r, ov_nxt;
  logic [31:0]       ochars_r, ochars_nxt;
  logic [2:0]        ocnt_r, ocnt_nxt;
  logic [CONS_W-1:0] ocons_r, ocons_nxt;
  logic [1:0]        ost_r, ost_nxt;
  logic              olast_r, olast_nxt;

  logic out_free;

  assign out_free = !ov_r || !out_stall;
  assign pk.hold  = ev.push && cnt_r == 3'd4 && !out_free;
  assign pk.busy  = pend_r;

  assign out_valid          = ov_r;
  assign out_name_chars     = ochars_r;
  assign out_char_count     = ocnt_r;
  assign out_bytes_consumed = ocons_r;
  assign out_decode_status  = ost_r;
  assign out_last_result    = olast_r;

  always_comb begin
    word_nxt   = word_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    fst_nxt    = fst_r;
    fcons_nxt  = fcons_r;
    ov_nxt     = ov_r && out_stall;
    ochars_nxt = ochars_r;
    ocnt_nxt   = ocnt_r;
    ocons_nxt  = ocons_r;
    ost_nxt    = ost_r;
    olast_nxt  = olast_r;

    if (pend_r) begin
      if (out_free) begin
        ov_nxt     = 1'b1;
        ochars_nxt = word_r;
        ocnt_nxt   = cnt_r;
        ocons_nxt  = fcons_r;
        ost_nxt    = fst_r;
        olast_nxt  = 1'b1;
        pend_nxt   = 1'b0;
        word_nxt   = '0;
        cnt_nxt    = '0;
      end
    end else if (!pk.hold) begin
      if (ev.push) begin
        if (cnt_r == 3'd4) begin
          // The full word is only known not to be the last once more follows.
          ov_nxt     = 1'b1;
          ochars_nxt = word_r;
          ocnt_nxt   = cnt_r;
          ocons_nxt  = '0;
          ost_nxt    = ST_OK;
          olast_nxt  = 1'b0;
          word_nxt   = {24'd0, ev.ch};
          cnt_nxt    = 3'd1;
        end else begin
          for (int i = 0; i < 4; i++) begin
            if (cnt_r == 3'(i)) begin
              word_nxt[i*8 +: 8] = ev.ch;
            end
          end
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      if (ev.finish) begin
        pend_nxt  = 1'b1;
        fst_nxt   = ev.status;
        fcons_nxt = ev.consumed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      pend_r <= 1'b0;
      cnt_r  <= '0;
      word_r <= '0;
    end else begin
      ov_r   <= ov_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      word_r <= word_nxt;
    end
    fst_r    <= fst_nxt;
    fcons_r  <= fcons_nxt;
    ochars_r <= ochars_nxt;
    ocnt_r   <= ocnt_nxt;
    ocons_r  <= ocons_nxt;
    ost_r    <= ost_nxt;
    olast_r  <= olast_nxt;
  end

endmodule

// File: hdl/dns_name_decompressor_core.sv
// Channel  | Signals                                              | Direction
// ---------+------------------------------------------------------+----------
// in       | in_valid/in_stall, command, byte_address, byte_value | request in
// out      | out_valid/out_stall, name_chars, char_count,         | result out
//          | bytes_consumed, decode_status, last_result           |
//
// A decode walks the name one packet byte per cycle, unless a stalled output holds
// the walk, through the single read port of the packet RAM.
// Reset clears control state only; packet memory is undefined until loaded,
// and no clearing pass is made. A stalled output register pauses the walk
// only when a further full word of characters has to leave.
//
// Top level of the DNS name decompressor; depends on dnd_pkg, dnd_ram,
// dnd_walker and dnd_packer.
module dns_name_decompressor_core
  import dnd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_command,
  input  logic [9:0]        in_byte_address,
  input  logic [7:0]        in_byte_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_name_chars,
  output logic [2:0]        out_char_count,
  output logic [CONS_W-1:0] out_bytes_consumed,
  output logic [1:0]        out_decode_status,
  output logic              out_last_result
);

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  dnd_event_t        ev;
  dnd_pk_stat_t      pk;

  dnd_ram #(
    .WIDTH(8),
    .DEPTH(PACKET_DEPTH)
  ) u_packet_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  dnd_walker u_walker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_byte_address(in_byte_address),
    .in_byte_value  (in_byte_value),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .pk             (pk),
    .ev             (ev)
  );

  dnd_packer u_packer (
    .clk               (clk),
    .rst_n             (rst_n),
    .ev                (ev),
    .pk                (pk),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_name_chars    (out_name_chars),
    .out_char_count    (out_char_count),
    .out_bytes_consumed(out_bytes_consumed),
    .out_decode_status (out_decode_status),
    .out_last_result   (out_last_result)
  );

endmodule

// File: hdl/dnd_checker.sv
// Port-level checks on the result channel of the DNS name decompressor.
// Depends on dnd_pkg; bound to dns_name_decompressor_core below.
module dnd_checker
  import dnd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [31:0]       out_name_chars,
  input logic [2:0]        out_char_count,
  input logic [CONS_W-1:0] out_bytes_consumed,
  input logic [1:0]        out_decode_status,
  input logic              out_last_result
);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_char_count <= 3'd4)
    else $error("character count above four");

  // Only the final word of a decode may be short, and only it carries status.
  a_mid_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |->
      out_char_count == 3'd4 && out_bytes_consumed == '0 &&
      out_decode_status == ST_OK)
    else $error("non-final result is not a full plain word");

  a_err_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_decode_status != ST_OK |-> out_bytes_consumed == '0)
    else $error("byte count reported on a failed decode");

  a_ok_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result && out_decode_status == ST_OK |->
      out_bytes_consumed != '0)
    else $error("successful decode reports no bytes used");

endmodule

bind dns_name_decompressor_core dnd_checker u_dnd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_name_chars    (out_name_chars),
  .out_char_count    (out_char_count),
  .out_bytes_consumed(out_bytes_consumed),
  .out_decode_status (out_decode_status),
  .out_last_result   (out_last_result)
);

// File: bench/dns_name_decompressor_core_tb.sv
// Testbench for dns_name_decompressor_core: loads a set of directed names, then
// decodes directed and random compressed names and checks every result word.
// Depends on dnd_pkg and the RTL of the decompressor.
module dns_name_decompressor_core_tb;
  import dnd_pkg::*;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        value;
  } pkt_request_t;

  typedef struct packed {
    logic [31:0]       chars;
    logic [2:0]        count;
    logic [CONS_W-1:0] consumed;
    logic [1:0]        status;
    logic              last;
  } name_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_command = CMD_LOAD;
  logic [9:0]        in_byte_address = '0;
  logic [7:0]        in_byte_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [31:0]       out_name_chars;
  logic [2:0]        out_char_count;
  logic [CONS_W-1:0] out_bytes_consumed;
  logic [1:0]        out_decode_status;
  logic              out_last_result;

  pkt_request_t request_q[$];
  name_word_t   name_word_q[$];
  pkt_request_t next_req;
  name_word_t   got_word;
  name_word_t   want_word;
  logic [7:0]   pkt_image [PACKET_DEPTH];
  bit           pkt_known [PACKET_DEPTH];
  logic [7:0]   pkt_mirror [PACKET_DEPTH];
  int           name_starts[$] = '{1, 5, 13, 20};
  int           directed_starts[$] = '{0, 1, 13, 20, 30, 40, 50, 52, 98, 100, 200, 470,
                                       1020, 1021, 1023};
  int           send_pct_by_phase[4] = '{0, 75, 0, 7};
  int           stall_pct_by_phase[4] = '{0, 0, 75, 7};
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           phase_items = 0;
  int           err_count = 0;
  int           rnd_start;

  dns_name_decompressor_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_byte_address    (in_byte_address),
    .in_byte_value      (in_byte_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_name_chars     (out_name_chars),
    .out_char_count     (out_char_count),
    .out_bytes_consumed (out_bytes_consumed),
    .out_decode_status  (out_decode_status),
    .out_last_result    (out_last_result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Walks the name in the mirrored packet and queues the result words it yields.
  function automatic void decode_name(input logic [ADDR_W-1:0] start);
    logic [7:0] text[$];
    logic [7:0] b;
    logic [7:0] b2;
    logic [1:0] status;
    logic       jumped;
    logic       first;
    logic       done;
    int         pos;
    int         hops;
    int         consumed;
    int         nres;
    int         cnt;
    name_word_t w;
    pos = start;
    hops = 0;
    consumed = 0;
    status = ST_OK;
    jumped = 1'b0;
    first = 1'b1;
    done = 1'b0;
    while (!done) begin
      if (pos >= PACKET_DEPTH) begin
        status = ST_RANGE;
        break;
      end
      b = pkt_mirror[pos];
      if (!jumped) consumed++;
      if (b == 8'd0) break;
      if (b >= PTR_MARK) begin
        if (pos + 1 >= PACKET_DEPTH) begin
          status = ST_RANGE;
          break;
        end
        b2 = pkt_mirror[pos + 1];
        if (!jumped) consumed++;
        if (hops >= HOP_LIMIT) begin
          status = ST_HOPS;
          break;
        end
        hops++;
        jumped = 1'b1;
        // Dropping the two marker bits leaves the 14-bit target offset.
        pos = {b[5:0], b2};
        continue;
      end
      if (!first) begin
        if (text.size() >= NAME_MAX) begin
          status = ST_LONG;
          break;
        end
        text.push_back(DOT_CHAR);
      end
      first = 1'b0;
      pos++;
      for (int k = 0; k < b; k++) begin
        if (pos >= PACKET_DEPTH) begin
          status = ST_RANGE;
          done = 1'b1;
          break;
        end
        if (!jumped) consumed++;
        if (text.size() >= NAME_MAX) begin
          status = ST_LONG;
          done = 1'b1;
          break;
        end
        text.push_back(pkt_mirror[pos]);
        pos++;
      end
    end
    if (status != ST_OK) consumed = 0;
    nres = (text.size() == 0) ? 1 : (text.size() + 3) / 4;
    for (int r = 0; r < nres; r++) begin
      cnt = text.size() - 4 * r;
      if (cnt > 4) cnt = 4;
      w = '0;
      for (int j = 0; j < cnt; j++) w.chars[8*j +: 8] = text[4*r + j];
      w.count = 3'(cnt);
      if (r == nres - 1) begin
        w.consumed = CONS_W'(consumed);
        w.status = status;
        w.last = 1'b1;
      end
      name_word_q.push_back(w);
    end
  endfunction

  // Queues a load and keeps the image of what the packet will hold.
  function automatic void queue_load(input int at, input logic [7:0] val);
    if (at < PACKET_DEPTH) begin
      pkt_image[at] = val;
      pkt_known[at] = 1'b1;
      request_q.push_back(pkt_request_t'{CMD_LOAD, at[ADDR_W-1:0], val});
      phase_items++;
    end
  endfunction

  function automatic void put_text(input int at, input string s);
    for (int i = 0; i < s.len(); i++) queue_load(at + i, s[i]);
  endfunction

  function automatic void queue_decode(input int at);
    request_q.push_back(pkt_request_t'{CMD_DECODE, at[ADDR_W-1:0], 8'($urandom)});
    phase_items++;
  endfunction

  // True when a walk from start reads only bytes that have been loaded.
  function automatic bit walk_defined(input int start);
    int         pos;
    int         hops;
    int         n;
    logic [7:0] b;
    logic       first;
    pos = start;
    hops = 0;
    n = 0;
    first = 1'b1;
    while (hops <= HOP_LIMIT) begin
      if (pos >= PACKET_DEPTH) return 1'b1;
      if (!pkt_known[pos]) return 1'b0;
      b = pkt_image[pos];
      if (b == 8'd0) return 1'b1;
      if (b >= PTR_MARK) begin
        if (pos + 1 >= PACKET_DEPTH) return 1'b1;
        if (!pkt_known[pos + 1]) return 1'b0;
        if (hops >= HOP_LIMIT) return 1'b1;
        hops++;
        pos = int'({b[5:0], pkt_image[pos + 1]});
        continue;
      end
      if (!first) begin
        if (n >= NAME_MAX) return 1'b1;
        n++;
      end
      first = 1'b0;
      pos++;
      for (int k = 0; k < b; k++) begin
        if (pos >= PACKET_DEPTH) return 1'b1;
        if (!pkt_known[pos]) return 1'b0;
        if (n >= NAME_MAX) return 1'b1;
        n++;
        pos++;
      end
    end
    return 1'b1;
  endfunction

  // Writes a fresh name of a few labels somewhere in the packet and decodes it if its walk reads only loaded bytes.
  // Some names are broken: a label may hold fewer bytes than its length claims.
  function automatic void queue_random_name();
    int   at;
    int   start;
    int   len;
    int   fill_len;
    int   target;
    logic broken;
    start = $urandom_range(PACKET_DEPTH - 1);
    at = start;
    broken = ($urandom_range(9) == 0);
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(19))
        0: len = $urandom_range(64, 191);
        1, 2: len = $urandom_range(9, 63);
        default: len = $urandom_range(1, 8);
      endcase
      queue_load(at, 8'(len));
      at++;
      fill_len = broken ? $urandom_range(len) : len;
      for (int k = 0; k < fill_len; k++) begin
        queue_load(at, 8'(($urandom_range(7) == 0) ? $urandom_range(255)
                                                   : $urandom_range(97, 122)));
        at++;
      end
    end
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: queue_load(at, 8'd0);
      6, 7, 8: begin
        target = name_starts[$urandom_range(name_starts.size() - 1)];
        queue_load(at, PTR_MARK | target[9:8]);
        queue_load(at + 1, target[7:0]);
      end
      default: begin
        queue_load(at, 8'($urandom_range(192, 255)));
        queue_load(at + 1, 8'($urandom_range(255)));
      end
    endcase
    name_starts.push_back(start);
    if (walk_defined(start)) queue_decode(start);
  endfunction

  function automatic void flag_mismatch(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    err_count++;
    if (err_count <= 50)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endfunction

  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid || name_word_q.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = request_q.pop_front();
        in_valid <= 1'b1;
        in_command <= next_req.command;
        in_byte_address <= next_req.addr;
        in_byte_value <= next_req.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got_word = name_word_t'{out_name_chars, out_char_count, out_bytes_consumed,
                                out_decode_status, out_last_result};
        if (name_word_q.size() == 0) begin
          err_count++;
          $display("%0t: result with no decode pending, expected none, actual %h",
                   $time, got_word);
        end else begin
          want_word = name_word_q.pop_front();
          if (got_word.chars !== want_word.chars)
            flag_mismatch("name_chars", want_word.chars, got_word.chars);
          if (got_word.count !== want_word.count)
            flag_mismatch("char_count", want_word.count, got_word.count);
          if (got_word.consumed !== want_word.consumed)
            flag_mismatch("bytes_consumed", want_word.consumed, got_word.consumed);
          if (got_word.status !== want_word.status)
            flag_mismatch("decode_status", want_word.status, got_word.status);
          if (got_word.last !== want_word.last)
            flag_mismatch("last_result", want_word.last, got_word.last);
        end
      end
      // The address is as wide as the memory, so every load lands.
      if (in_valid && !in_stall) begin
        if (in_command == CMD_LOAD) pkt_mirror[in_byte_address] = in_byte_value;
        else decode_name(in_byte_address);
      end
    end
  end

  initial begin
    // Only the bytes of the directed names are loaded; a decode is queued only
    // where its walk stays on loaded bytes.
    queue_load(0, 8'd0);
    put_text(1, "\003www\007example\003com");
    queue_load(17, 8'd0);
    put_text(20, "\004mail");
    queue_load(25, PTR_MARK);
    queue_load(26, 8'd5);
    queue_load(30, PTR_MARK);
    queue_load(31, 8'd1);
    // A pointer to itself, and pointers beyond the packet.
    queue_load(40, PTR_MARK);
    queue_load(41, 8'd40);
    queue_load(50, 8'hC4);
    queue_load(51, 8'h00);
    queue_load(52, 8'hFF);
    queue_load(53, 8'hFF);
    // A chain of exactly the allowed number of hops from 100, one more from 98.
    queue_load(98, PTR_MARK);
    queue_load(99, 8'd100);
    for (int i = 0; i < HOP_LIMIT; i++) begin
      queue_load(100 + 2*i, PTR_MARK);
      queue_load(101 + 2*i, 8'(102 + 2*i));
    end
    queue_load(100 + 2*HOP_LIMIT, 8'd0);
    // A 63-byte label that points back to itself, so the name grows until it
    // is too long on a dot; entered after one letter, it overflows on a
    // character instead. The contents are random, zeros and pointer-like
    // values among them.
    queue_load(200, 8'd63);
    for (int k = 1; k <= 63; k++) queue_load(200 + k, 8'($urandom_range(255)));
    queue_load(264, PTR_MARK);
    queue_load(265, 8'd200);
    queue_load(470, 8'd1);
    queue_load(471, "q");
    queue_load(472, PTR_MARK);
    queue_load(473, 8'd200);
    put_text(1020, "\002ab");
    queue_load(1023, PTR_MARK);

    foreach (directed_starts[i]) queue_decode(directed_starts[i]);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pct_by_phase[p];
      recv_stall_pct = stall_pct_by_phase[p];
      phase_items = 0;
      while (phase_items < 40) begin
        case ($urandom_range(9))
          0: queue_load($urandom_range(PACKET_DEPTH - 1), 8'($urandom_range(255)));
          1: begin
            rnd_start = $urandom_range(PACKET_DEPTH - 1);
            if (walk_defined(rnd_start)) queue_decode(rnd_start);
          end
          default: queue_random_name();
        endcase
      end
      wait_drained();
    end

    // Leave room for a stray result after the last expected one.
    repeat (400) @(posedge clk);
    if (err_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
